/* rtl/core/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NULL  = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    capture;
		logic    idx_init;
		logic    rd_prev;
		logic    rd_head;
		logic    shift;
		logic    insert;
		logic    pop;
		logic    ld_res;
		status_t res_status;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic req_op;
		logic req_null;
		logic full;
		logic empty;
		logic idx_zero;
		logic prev_lt;
		logic can_load;
	} sts_t;

endpackage

/* rtl/core/spq_ctrl.sv */
`timescale 1ns / 1ps

module spq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spq_pkg::sts_t sts,
	output spq_pkg::cmd_t cmd
);
	import spq_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CHECK = 5'b00010,
		S_SEEK  = 5'b00100,
		S_CMP   = 5'b01000,
		S_POP   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign req_stall = !((state_q == S_IDLE) && sts.can_load);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.res_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (req_valid && !req_stall) begin
					cmd.capture = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.req_op == OP_ENQ) begin
					if (sts.req_null) begin
						cmd.ld_res = 1'b1;
						cmd.res_status = ST_NULL;
						state_d = S_IDLE;
					end else if (sts.full) begin
						cmd.ld_res = 1'b1;
						cmd.res_status = ST_FULL;
						state_d = S_IDLE;
					end else begin
						cmd.idx_init = 1'b1;
						state_d = S_SEEK;
					end
				end else begin
					if (sts.empty) begin
						cmd.ld_res = 1'b1;
						cmd.res_status = ST_EMPTY;
						state_d = S_IDLE;
					end else begin
						cmd.rd_head = 1'b1;
						state_d = S_POP;
					end
				end
			end
			S_SEEK: begin
				if (sts.idx_zero) begin
					cmd.insert = 1'b1;
					cmd.ld_res = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				// stop behind the first entry with a strictly smaller key
				if (sts.prev_lt) begin
					cmd.insert = 1'b1;
					cmd.ld_res = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.shift = 1'b1;
					state_d = S_SEEK;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				cmd.ld_res = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/spq_dpath.sv */
`timescale 1ns / 1ps

module spq_dpath #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  spq_pkg::cmd_t cmd,
	output spq_pkg::sts_t sts,
	input  logic          op,
	input  logic [31:0]   item_key,
	input  logic [31:0]   item_handle,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output logic [1:0]    status,
	output logic [31:0]   head_key,
	output logic [31:0]   head_handle,
	output logic [4:0]    entries_held
);
	import spq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

	// entry storage, key in the upper half
	logic [63:0] mem [DEPTH];

	logic [AW-1:0] head_q;
	logic [CW-1:0] occ_q, occ_d;
	logic [CW-1:0] idx_q;
	logic          req_op_q;
	logic [31:0]   req_key_q;
	logic [31:0]   req_handle_q;
	logic [63:0]   rd_data_q;

	logic          rsp_valid_q;
	logic [1:0]    status_q;
	logic [31:0]   head_key_q;
	logic [31:0]   head_handle_q;
	logic [4:0]    held_q;

	logic [AW:0]   wr_sum, rd_sum;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [63:0]   wr_data;

	// logical position -> physical slot of the circular store
	assign wr_sum  = {1'b0, head_q} + (AW + 1)'(idx_q);
	assign rd_sum  = {1'b0, head_q} + (AW + 1)'(idx_q - CW'(1));
	assign wr_addr = (wr_sum >= DEPTH_W) ? AW'(wr_sum - DEPTH_W) : wr_sum[AW-1:0];
	assign rd_addr = cmd.rd_head ? head_q :
		((rd_sum >= DEPTH_W) ? AW'(rd_sum - DEPTH_W) : rd_sum[AW-1:0]);
	assign wr_data = cmd.shift ? rd_data_q : {req_key_q, req_handle_q};

	always_ff @(posedge clk) begin
		if (cmd.shift || cmd.insert) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_prev || cmd.rd_head) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_op_q     <= op;
			req_key_q    <= item_key;
			req_handle_q <= item_handle;
		end
		if (cmd.idx_init) begin
			idx_q <= occ_q;
		end else if (cmd.shift) begin
			idx_q <= idx_q - CW'(1);
		end
	end

	always_comb begin
		occ_d = occ_q;
		if (cmd.insert) begin
			occ_d = occ_q + CW'(1);
		end else if (cmd.pop) begin
			occ_d = occ_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			head_q <= '0;
		end else begin
			occ_q <= occ_d;
			if (cmd.pop) begin
				head_q <= (head_q == LAST) ? '0 : head_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.ld_res) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_res) begin
			status_q      <= cmd.res_status;
			head_key_q    <= cmd.pop ? rd_data_q[63:32] : 32'd0;
			head_handle_q <= cmd.pop ? rd_data_q[31:0] : 32'd0;
			held_q        <= 5'(occ_d);
		end
	end

	assign sts.req_op   = req_op_q;
	assign sts.req_null = (req_handle_q == 32'd0);
	assign sts.full     = (occ_q == CW'(DEPTH));
	assign sts.empty    = (occ_q == '0);
	assign sts.idx_zero = (idx_q == '0);
	assign sts.prev_lt  = (rd_data_q[63:32] < req_key_q);
	assign sts.can_load = !rsp_valid_q || !rsp_stall;

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign head_key     = head_key_q;
	assign head_handle  = head_handle_q;
	assign entries_held = held_q;

endmodule

/* rtl/core/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// One item at a time. A refused item or an empty dequeue hands over its result from the check
// state, a dequeue reads the head and then pops it, and an enqueue steps back from the tail
// one entry at a time until it finds its place; each moved entry costs a read and a write of the
// single-port entry store. The next item is taken at the edge that drains the result.
// Reset clears occupancy, head pointer, controller and result valid; entries are not cleared.
module sorted_priority_queue #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        op,
	input  logic [31:0] item_key,
	input  logic [31:0] item_handle,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [31:0] head_key,
	output logic [31:0] head_handle,
	output logic [4:0]  entries_held
);
	import spq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	spq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.item_key     (item_key),
		.item_handle  (item_handle),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.head_key     (head_key),
		.head_handle  (head_handle),
		.entries_held (entries_held)
	);

endmodule
